/* src/lzrle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE decompressor package
// Shared types, codes and helpers for the LZ/RLE byte decompressor.
// ----------------------------------------------------------------------------
package lzrle_pkg;

  // Field and state widths fixed by the stream format.
  localparam int BYTE_W = 8;
  localparam int ACT_W  = 2;
  localparam int LEN_W  = 11;
  localparam int CPW    = 18;

  localparam logic [BYTE_W-1:0] END_BYTE = 8'hFF;

  // Action codes carried on the input channel.
  localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PULL    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // Command kinds held in the top three bits of an opcode.
  localparam logic [2:0] KIND_LITERAL   = 3'd0;
  localparam logic [2:0] KIND_BYTE_FILL = 3'd1;
  localparam logic [2:0] KIND_WORD_FILL = 3'd2;
  localparam logic [2:0] KIND_INC_FILL  = 3'd3;
  localparam logic [2:0] KIND_FWD_COPY  = 3'd4;
  localparam logic [2:0] KIND_REV_COPY  = 3'd5;
  localparam logic [2:0] KIND_BACK_COPY = 3'd6;
  localparam logic [2:0] KIND_LONG      = 3'd7;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_BYTE   = 3'd1,
    ST_NEED   = 3'd2,
    ST_ENDED  = 3'd3,
    ST_BADOP  = 3'd4,
    ST_BADREF = 3'd5,
    ST_REJECT = 3'd6
  } status_t;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_INVALID = 2'd3
  } op_t;

  // A classified input beat. The opcode fields only matter when the
  // decoder is waiting for an opcode.
  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
    logic             end_mark;
    logic             long_form;
    logic [2:0]       kind;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data;
  } res_t;

  // Mirror the bit order of a byte.
  function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[BYTE_W-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

/* src/lzrle_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE front end
// Accepts input beats, classifies action and opcode fields, and holds them
// in a two-entry queue ahead of the decode engine.
// ----------------------------------------------------------------------------
module lzrle_front
  import lzrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [BYTE_W-1:0] in_byte,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_pop
);

  localparam int QDEPTH = 2;

  cmd_t       q_r [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  cmd_t       cls;
  logic       do_wr;
  logic       do_rd;

  // Classify the incoming beat.
  always_comb begin
    cls           = '0;
    cls.data      = in_byte;
    cls.end_mark  = (in_byte == END_BYTE);
    cls.long_form = (in_byte[7:5] == KIND_LONG);
    unique case (in_action)
      ACT_PUSH:    cls.op = OP_PUSH;
      ACT_PULL:    cls.op = OP_PULL;
      ACT_RESTART: cls.op = OP_RESTART;
      default:     cls.op = OP_INVALID;
    endcase
    if (cls.long_form) begin
      cls.kind = in_byte[4:2];
      cls.len  = {1'b0, in_byte[1:0], 8'h00};
    end else begin
      cls.kind = in_byte[7:5];
      cls.len  = LEN_W'(in_byte[4:0]) + LEN_W'(1);
    end
  end

  assign full      = (cnt_r == 2'(QDEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_pop && cmd_valid;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* src/lzrle_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE decode engine
// Executes one classified beat per cycle unless stalled: runs the command
// state machine, produces one result and keeps decoded history for copy commands.
// ----------------------------------------------------------------------------
module lzrle_back
  import lzrle_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int WCW  = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (CPW > WCW) ? CPW : WCW;

  typedef enum logic [9:0] {
    PH_OPCODE    = 10'b00_0000_0001,
    PH_LONGLEN   = 10'b00_0000_0010,
    PH_ARG1      = 10'b00_0000_0100,
    PH_ARG2      = 10'b00_0000_1000,
    PH_LITERAL   = 10'b00_0001_0000,
    PH_LIT_READY = 10'b00_0010_0000,
    PH_RUN       = 10'b00_0100_0000,
    PH_ENDED     = 10'b00_1000_0000,
    PH_BAD_OP    = 10'b01_0000_0000,
    PH_BAD_REF   = 10'b10_0000_0000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] fill2_r, fill2_nxt;
  logic              half_r, half_nxt;
  logic [CPW-1:0]    cp_r, cp_nxt;
  logic [WCW-1:0]    wc_r, wc_nxt;

  logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] byp_data_r;
  logic              byp_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] hist_q;

  logic              step;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic [LEN_W-1:0]  rem_dec;
  logic              last_unit;
  logic              is_copy;
  logic              hist_full;
  logic              ref_bad;
  status_t           status;

  assign step      = cmd_valid && !res_full;
  assign cmd_pop   = step;
  assign res_push  = step;
  assign rem_dec   = rem_r - LEN_W'(1);
  assign last_unit = (rem_dec == '0);
  assign is_copy   = (kind_r == KIND_FWD_COPY) || (kind_r == KIND_REV_COPY) ||
                     (kind_r == KIND_BACK_COPY);
  assign hist_full = (wc_r == WCW'(HISTORY_DEPTH));
  assign ref_bad   = (CMPW'(cp_r) >= CMPW'(wc_r));
  assign hist_q    = byp_r ? byp_data_r : rd_data_r;

  // Command state machine: one beat in, one result out.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    rem_nxt   = rem_r;
    fill_nxt  = fill_r;
    fill2_nxt = fill2_r;
    half_nxt  = half_r;
    cp_nxt    = cp_r;
    wc_nxt    = wc_r;
    status    = ST_REJECT;
    emit      = 1'b0;
    emit_byte = '0;
    wr_en     = 1'b0;
    wr_data   = '0;
    if (step) begin
      unique case (cmd.op)
        OP_PUSH: begin
          unique case (phase_r)
            PH_OPCODE: begin
              status = ST_ACCEPT;
              if (cmd.end_mark) begin
                phase_nxt = PH_ENDED;
              end else if (cmd.long_form && (cmd.kind == KIND_LONG)) begin
                kind_nxt  = cmd.kind;
                phase_nxt = PH_BAD_OP;
                status    = ST_BADOP;
              end else begin
                kind_nxt = cmd.kind;
                rem_nxt  = cmd.len;
                half_nxt = 1'b0;
                if (cmd.long_form) begin
                  phase_nxt = PH_LONGLEN;
                end else begin
                  phase_nxt = (cmd.kind == KIND_LITERAL) ? PH_LITERAL : PH_ARG1;
                end
              end
            end
            PH_LONGLEN: begin
              status    = ST_ACCEPT;
              rem_nxt   = rem_r + LEN_W'(cmd.data) + LEN_W'(1);
              phase_nxt = (kind_r == KIND_LITERAL) ? PH_LITERAL : PH_ARG1;
            end
            PH_ARG1: begin
              status = ST_ACCEPT;
              if (is_copy) begin
                cp_nxt    = CPW'({cmd.data, 8'h00});
                phase_nxt = PH_ARG2;
              end else begin
                fill_nxt  = cmd.data;
                phase_nxt = (kind_r == KIND_WORD_FILL) ? PH_ARG2 : PH_RUN;
              end
            end
            PH_ARG2: begin
              status = ST_ACCEPT;
              if (is_copy) begin
                cp_nxt = cp_r | CPW'(cmd.data);
              end else begin
                fill2_nxt = cmd.data;
              end
              phase_nxt = PH_RUN;
            end
            PH_LITERAL: begin
              status    = ST_ACCEPT;
              fill_nxt  = cmd.data;
              phase_nxt = PH_LIT_READY;
            end
            PH_ENDED:   status = ST_ENDED;
            PH_BAD_OP:  status = ST_BADOP;
            PH_BAD_REF: status = ST_BADREF;
            default:    status = ST_REJECT;
          endcase
        end
        OP_PULL: begin
          unique case (phase_r)
            PH_LIT_READY: begin
              emit      = 1'b1;
              emit_byte = fill_r;
              rem_nxt   = rem_dec;
              phase_nxt = last_unit ? PH_OPCODE : PH_LITERAL;
            end
            PH_RUN: begin
              if (kind_r == KIND_BYTE_FILL) begin
                emit      = 1'b1;
                emit_byte = fill_r;
                rem_nxt   = rem_dec;
                if (last_unit) phase_nxt = PH_OPCODE;
              end else if (kind_r == KIND_WORD_FILL) begin
                emit = 1'b1;
                if (!half_r) begin
                  emit_byte = fill_r;
                  half_nxt  = 1'b1;
                end else begin
                  emit_byte = fill2_r;
                  half_nxt  = 1'b0;
                  rem_nxt   = rem_dec;
                  if (last_unit) phase_nxt = PH_OPCODE;
                end
              end else if (kind_r == KIND_INC_FILL) begin
                emit      = 1'b1;
                emit_byte = fill_r;
                fill_nxt  = fill_r + BYTE_W'(1);
                rem_nxt   = rem_dec;
                if (last_unit) phase_nxt = PH_OPCODE;
              end else if (ref_bad) begin
                phase_nxt = PH_BAD_REF;
                status    = ST_BADREF;
              end else begin
                emit      = 1'b1;
                emit_byte = (kind_r == KIND_REV_COPY) ? flip_bits(hist_q) : hist_q;
                cp_nxt    = (kind_r == KIND_BACK_COPY) ? cp_r - CPW'(1)
                                                       : cp_r + CPW'(1);
                rem_nxt   = rem_dec;
                if (last_unit) phase_nxt = PH_OPCODE;
              end
            end
            PH_ENDED:   status = ST_ENDED;
            PH_BAD_OP:  status = ST_BADOP;
            PH_BAD_REF: status = ST_BADREF;
            default:    status = ST_NEED;
          endcase
        end
        OP_RESTART: begin
          status    = ST_ACCEPT;
          phase_nxt = PH_OPCODE;
          kind_nxt  = '0;
          rem_nxt   = '0;
          fill_nxt  = '0;
          fill2_nxt = '0;
          half_nxt  = 1'b0;
          cp_nxt    = '0;
          wc_nxt    = '0;
        end
        default: status = ST_REJECT;
      endcase

      // A decoded byte is output and, while there is room, kept in history.
      if (emit) begin
        status = ST_BYTE;
        if (!hist_full) begin
          wr_en   = 1'b1;
          wr_data = emit_byte;
          wc_nxt  = wc_r + WCW'(1);
        end
      end
    end
  end

  assign res.status = status;
  assign res.data   = emit_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      kind_r  <= '0;
      rem_r   <= '0;
      fill_r  <= '0;
      fill2_r <= '0;
      half_r  <= 1'b0;
      cp_r    <= '0;
      wc_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      rem_r   <= rem_nxt;
      fill_r  <= fill_nxt;
      fill2_r <= fill2_nxt;
      half_r  <= half_nxt;
      cp_r    <= cp_nxt;
      wc_r    <= wc_nxt;
    end
  end

  // History memory. The read address follows the next copy pointer so the
  // byte is ready when the following beat arrives; a write to the same
  // address in that cycle is forwarded around the memory.
  assign rd_addr = cp_nxt[AW-1:0];
  assign wr_addr = wc_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= hist_mem[rd_addr];
    byp_r      <= wr_en && (wr_addr == rd_addr);
    byp_data_r <= wr_data;
  end

endmodule

/* src/lzrle_resq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE result queue
// Two-entry queue that holds result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module lzrle_resq
  import lzrle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output res_t head
);

  localparam int QDEPTH = 2;

  res_t       q_r [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       do_wr;
  logic       do_rd;

  assign res_full = (cnt_r == 2'(QDEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign head     = q_r[rd_ptr_r];
  assign do_wr    = res_push && !res_full;
  assign do_rd    = pop && !empty;

  // Pointers and fill count.
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

/* src/lz_rle_byte_decompressor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE byte decompressor
// Decodes a pushed compressed byte stream with literal, fill and copy
// commands and answers every beat with one status and byte result.
// ----------------------------------------------------------------------------
//  Channel  Ports                                 Accepted when
//  input    push, full, in_action, in_byte        push && !full
//  result   empty, pop, out_status, out_byte      pop && !empty
//
// One beat is decoded per cycle while neither side stalls; both may stall freely.
// A beat is registered in the input queue; once the result queue has room,
// the decode engine answers it straight into the result queue. The history
// memory read is registered and issued from the next copy pointer, so copies
// run at full rate as well. Reset is synchronous and clears the control
// state; the history memory needs no clearing pass.
// ----------------------------------------------------------------------------
module lz_rle_byte_decompressor_unit
  import lzrle_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        out_status,
  output logic [BYTE_W-1:0] out_byte
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res;
  res_t head;

  // Front end: classify and queue input beats.
  lzrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_action (in_action),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Decode engine with history memory.
  lzrle_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue towards the consumer.
  lzrle_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_status = head.status;
  assign out_byte   = head.data;

  // The engine only produces a result for a queued beat and never into a
  // full result queue.
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (cmd_valid && !res_full))
    else $error("result written without a beat or into a full queue");

  // Every consumed beat is answered in the same cycle.
  a_pop_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop == res_push)
    else $error("beat consumed without a result");

  // Only byte results carry data.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status != ST_BYTE)) |-> (out_byte == '0))
    else $error("non-byte result carries data");

  // Status codes stay within the defined set.
  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status <= ST_REJECT))
    else $error("undefined status code");

endmodule

/* bench/lz_rle_byte_decompressor_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ/RLE byte decompressor testbench
// Drives push, pull and restart beats into the decompressor and predicts
// every answer with a behavioural decoder that keeps its own history copy.
// The tests cover each command kind in short and long form, error and end
// states, random streams and input/output stalls.
// ----------------------------------------------------------------------------
module lz_rle_byte_decompressor_unit_tb;
  import lzrle_pkg::*;

  localparam int HIST_DEPTH = 65536;

  // The action code that the decoder answers with a rejection.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  // Decoder phases of the predictor.
  typedef enum logic [3:0] {
    PH_OPCODE, PH_LONGLEN, PH_ARG1, PH_ARG2, PH_LITERAL,
    PH_LIT_READY, PH_RUN, PH_ENDED, PH_BAD_OP, PH_BAD_REF
  } phase_e;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [ACT_W-1:0]  in_action = ACT_PULL;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [2:0]        out_status;
  logic [BYTE_W-1:0] out_byte;

  // Predicted decoder state.
  phase_e            ph;
  logic [2:0]        cmd_kind;
  logic [LEN_W-1:0]  units_left;
  logic [BYTE_W-1:0] fill_lo;
  logic [BYTE_W-1:0] fill_hi;
  logic              word_second;
  logic [CPW-1:0]    src_ptr;
  logic [16:0]       hist_len;
  logic [BYTE_W-1:0] hist_mem [HIST_DEPTH];

  // Answers that are predicted but not yet seen.
  res_t answer_q [$];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int rx_hold_cycles = 0;
  int error_count = 0;
  int beats_sent = 0;
  int answers_checked = 0;
  int status_tally [8];

  lz_rle_byte_decompressor_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_action(in_action),
    .in_byte(in_byte),
    .empty(empty),
    .pop(pop),
    .out_status(out_status),
    .out_byte(out_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous overall limit; a correct run takes a small fraction of it.
  initial begin
    #20_000_000;
    $display("Timeout with %0d answers outstanding.", answer_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A restart clears everything but the history contents.
  function void restart_decoder();
    ph = PH_OPCODE;
    cmd_kind = KIND_LITERAL;
    units_left = '0;
    fill_lo = '0;
    fill_hi = '0;
    word_second = 1'b0;
    src_ptr = '0;
    hist_len = '0;
  endfunction

  function void open_command();
    ph = (cmd_kind == KIND_LITERAL) ? PH_LITERAL : PH_ARG1;
  endfunction

  // One byte or word of the command is done.
  function void unit_done();
    units_left = units_left - LEN_W'(1);
    if (units_left == '0) ph = PH_OPCODE;
  endfunction

  // Decoded bytes are stored until the history is full.
  function void keep_byte(input logic [BYTE_W-1:0] v);
    if (hist_len < 17'(HIST_DEPTH)) begin
      hist_mem[hist_len[15:0]] = v;
      hist_len = hist_len + 17'(1);
    end
  endfunction

  function status_t push_byte(input logic [BYTE_W-1:0] b);
    status_t st;
    st = ST_ACCEPT;
    case (ph)
      PH_OPCODE: begin
        if (b == END_BYTE) begin
          ph = PH_ENDED;
        end else if (b[7:5] == KIND_LONG) begin
          cmd_kind = b[4:2];
          if (cmd_kind == KIND_LONG) begin
            ph = PH_BAD_OP;
            st = ST_BADOP;
          end else begin
            units_left = {1'b0, b[1:0], 8'h00};
            ph = PH_LONGLEN;
            word_second = 1'b0;
          end
        end else begin
          cmd_kind = b[7:5];
          units_left = LEN_W'(b[4:0]) + LEN_W'(1);
          open_command();
          word_second = 1'b0;
        end
      end
      PH_LONGLEN: begin
        units_left = units_left + LEN_W'(b) + LEN_W'(1);
        open_command();
      end
      PH_ARG1: begin
        if (cmd_kind >= KIND_FWD_COPY) begin
          src_ptr = {2'b00, b, 8'h00};
          ph = PH_ARG2;
        end else begin
          fill_lo = b;
          ph = (cmd_kind == KIND_WORD_FILL) ? PH_ARG2 : PH_RUN;
        end
      end
      PH_ARG2: begin
        if (cmd_kind >= KIND_FWD_COPY) src_ptr = src_ptr | CPW'(b);
        else fill_hi = b;
        ph = PH_RUN;
      end
      PH_LITERAL: begin
        fill_lo = b;
        ph = PH_LIT_READY;
      end
      PH_ENDED:   st = ST_ENDED;
      PH_BAD_OP:  st = ST_BADOP;
      PH_BAD_REF: st = ST_BADREF;
      default:    st = ST_REJECT;
    endcase
    return st;
  endfunction

  function status_t pull_byte(output logic [BYTE_W-1:0] v);
    status_t st;
    logic [BYTE_W-1:0] raw;
    st = ST_BYTE;
    v = '0;
    case (ph)
      PH_LIT_READY: begin
        v = fill_lo;
        keep_byte(v);
        ph = PH_LITERAL;
        unit_done();
      end
      PH_RUN: begin
        case (cmd_kind)
          KIND_BYTE_FILL: begin
            v = fill_lo;
            unit_done();
          end
          KIND_WORD_FILL: begin
            if (!word_second) begin
              v = fill_lo;
              word_second = 1'b1;
            end else begin
              v = fill_hi;
              word_second = 1'b0;
              unit_done();
            end
          end
          KIND_INC_FILL: begin
            v = fill_lo;
            fill_lo = fill_lo + BYTE_W'(1);
            unit_done();
          end
          default: begin
            // Copies read back history; a pointer past it is a bad reference.
            if (src_ptr >= CPW'(hist_len)) begin
              ph = PH_BAD_REF;
              st = ST_BADREF;
            end else begin
              raw = hist_mem[src_ptr[15:0]];
              v = (cmd_kind == KIND_REV_COPY) ? {<<{raw}} : raw;
              if (cmd_kind == KIND_BACK_COPY) src_ptr = src_ptr - CPW'(1);
              else src_ptr = src_ptr + CPW'(1);
              unit_done();
            end
          end
        endcase
        if (st == ST_BYTE) keep_byte(v);
      end
      PH_ENDED:   st = ST_ENDED;
      PH_BAD_OP:  st = ST_BADOP;
      PH_BAD_REF: st = ST_BADREF;
      default:    st = ST_NEED;
    endcase
    return st;
  endfunction

  // Predict the answer to one accepted beat and queue it.
  function void decode_beat(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b);
    res_t r;
    logic [BYTE_W-1:0] v;
    v = '0;
    case (act)
      ACT_PUSH: r.status = push_byte(b);
      ACT_PULL: r.status = pull_byte(v);
      ACT_RESTART: begin
        restart_decoder();
        r.status = ST_ACCEPT;
      end
      default: r.status = ST_REJECT;
    endcase
    r.data = v;
    answer_q.push_back(r);
    status_tally[r.status]++;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("MISMATCH at %0t, answer %0d: %s is %0h, expected %0h",
               $time, answers_checked, what, got, want);
    end
  endtask

  // Pulls answers with random stalls and compares them with the oldest prediction.
  initial begin : answer_checker
    int stall;
    bit taken;
    logic [2:0] got_status;
    logic [BYTE_W-1:0] got_byte;
    res_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 11) : 0;
      stall += rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !empty;
        got_status = out_status;
        got_byte = out_byte;
        @(posedge clk);
      end while (!taken);
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected answer status", 8'(got_status), 8'h00);
      end else begin
        want = answer_q.pop_front();
        if (got_status !== want.status)
          report_mismatch("status", 8'(got_status), 8'(want.status));
        if (got_byte !== want.data) report_mismatch("out_byte", got_byte, want.data);
      end
      answers_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap and wait until it is taken.
  task send_beat(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b);
    int gap;
    bit taken;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_byte <= b;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    decode_beat(act, b);
    beats_sent++;
  endtask

  // The sender stops until every predicted answer has been checked.
  task wait_answers_drained();
    if (answer_q.size() != 0) begin
      push <= 1'b0;
      while (answer_q.size() != 0) @(posedge clk);
    end
  endtask

  // Opcode and argument bytes of one command; long form when asked or needed.
  task send_command(input logic [2:0] kind, input int len, input bit long_form,
                    input logic [15:0] arg);
    if (long_form || len > 32) begin
      send_beat(ACT_PUSH, {KIND_LONG, kind, 2'((len - 1) >> 8)});
      send_beat(ACT_PUSH, 8'(len - 1));
    end else begin
      send_beat(ACT_PUSH, {kind, 5'(len - 1)});
    end
    if (kind != KIND_LITERAL) send_beat(ACT_PUSH, arg[15:8]);
    if (kind == KIND_WORD_FILL || kind >= KIND_FWD_COPY) send_beat(ACT_PUSH, arg[7:0]);
  endtask

  // Supply literal bytes and pull until the command is over.
  task finish_command();
    while (ph == PH_LITERAL || ph == PH_LIT_READY || ph == PH_RUN) begin
      if (ph == PH_LITERAL) send_beat(ACT_PUSH, 8'($urandom));
      else send_beat(ACT_PULL, 8'($urandom));
    end
  endtask

  function int pick_length();
    if ($urandom_range(0, 24) == 0) return 256 + $urandom_range(1, 256);
    return $urandom_range(1, 32);
  endfunction

  // Start a random command, mostly well formed, sometimes an end, restart, error or noise.
  task random_command();
    int r;
    int len;
    int wide;
    logic [2:0] kind;
    logic [15:0] arg;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_beat(ACT_PUSH, END_BYTE);
    end else if (r < 5) begin
      send_beat(ACT_RESTART, 8'($urandom));
    end else if (r < 7) begin
      send_beat(ACT_PUSH, {KIND_LONG, KIND_LONG, 2'($urandom)});
    end else if (r < 12) begin
      send_beat(2'($urandom), 8'($urandom));
    end else begin
      kind = 3'($urandom_range(0, 6));
      if (kind >= KIND_FWD_COPY && hist_len == 0) kind = KIND_BYTE_FILL;
      len = pick_length();
      arg = 16'($urandom);
      if (kind >= KIND_FWD_COPY) begin
        if ($urandom_range(0, 9) == 0) begin
          wide = hist_len + $urandom_range(0, 255);
          arg = (wide > 32'hFFFF) ? 16'hFFFF : 16'(wide);
        end else begin
          arg = 16'($urandom_range(0, hist_len - 1));
          // Keep most backward copies from running below position zero.
          if (kind == KIND_BACK_COPY && $urandom_range(0, 7) != 0 && len > arg + 1)
            len = arg + 1;
        end
      end
      send_command(kind, len, $urandom_range(0, 4) == 0, arg);
    end
  endtask

  // Random stream driven by the predicted phase, with noise in every phase.
  task play_stream(input int n_beats);
    int start;
    int r;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      r = $urandom_range(0, 29);
      case (ph)
        PH_OPCODE: random_command();
        PH_LONGLEN, PH_ARG1, PH_ARG2, PH_LITERAL: begin
          if (r == 0) send_beat(ACT_PULL, 8'($urandom));
          else if (r == 1) send_beat(ACT_SPARE, 8'($urandom));
          else send_beat(ACT_PUSH, 8'($urandom));
        end
        PH_LIT_READY, PH_RUN: begin
          if (r == 0) send_beat(ACT_PUSH, 8'($urandom));
          else if (r == 1) send_beat(ACT_SPARE, 8'($urandom));
          else send_beat(ACT_PULL, 8'($urandom));
        end
        default: begin
          // Ended or failed: poke it a little, then restart.
          if (r < 4) send_beat(ACT_PUSH, 8'($urandom));
          else if (r < 8) send_beat(ACT_PULL, 8'($urandom));
          else if (r < 10) send_beat(ACT_SPARE, 8'($urandom));
          else send_beat(ACT_RESTART, 8'($urandom));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command kind once, plus a pull with no input and the spare action.
  task test_command_kinds();
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_SPARE, 8'hFF);
    send_command(KIND_LITERAL, 2, 1'b0, 16'h0000);
    send_beat(ACT_PUSH, 8'h00);
    send_beat(ACT_PUSH, 8'hAA);
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_PUSH, 8'hFF);
    send_beat(ACT_PULL, 8'h00);
    send_command(KIND_BYTE_FILL, 1, 1'b0, 16'h5A00);
    finish_command();
    send_command(KIND_WORD_FILL, 1, 1'b0, 16'h1234);
    finish_command();
    send_command(KIND_INC_FILL, 2, 1'b0, 16'hFF00);
    finish_command();
    send_command(KIND_FWD_COPY, 2, 1'b0, 16'h0000);
    finish_command();
    send_command(KIND_REV_COPY, 1, 1'b0, 16'h0001);
    finish_command();
    send_command(KIND_BACK_COPY, 2, 1'b0, 16'h0003);
    finish_command();
    wait_answers_drained();
  endtask

  // Long lengths, the end byte, a bad long opcode, bad references, mid-run restart.
  task test_long_form_and_errors();
    send_command(KIND_WORD_FILL, 3, 1'b1, 16'hC33C);
    finish_command();
    send_command(KIND_INC_FILL, 300, 1'b1, 16'h8000);
    finish_command();
    send_beat(ACT_PUSH, {KIND_LONG, KIND_LONG, 2'b11});
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_PUSH, 8'h00);
    send_beat(ACT_RESTART, 8'h00);
    send_beat(ACT_PUSH, END_BYTE);
    send_beat(ACT_PUSH, 8'h01);
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_RESTART, 8'hFF);
    // Forward copy that starts at the first unwritten position.
    send_command(KIND_BYTE_FILL, 4, 1'b0, 16'h7700);
    finish_command();
    send_command(KIND_FWD_COPY, 2, 1'b0, 16'h0004);
    finish_command();
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_PUSH, 8'h00);
    send_beat(ACT_RESTART, 8'h00);
    // Backward copy that steps below position zero.
    send_command(KIND_INC_FILL, 4, 1'b0, 16'h1000);
    finish_command();
    send_command(KIND_BACK_COPY, 3, 1'b0, 16'h0001);
    finish_command();
    send_beat(ACT_RESTART, 8'h00);
    send_command(KIND_BYTE_FILL, 2, 1'b0, 16'h3300);
    finish_command();
    send_command(KIND_FWD_COPY, 1, 1'b0, 16'hFFFF);
    finish_command();
    send_beat(ACT_RESTART, 8'h00);
    // Restart in the middle of a run.
    send_command(KIND_BYTE_FILL, 5, 1'b0, 16'h4400);
    send_beat(ACT_PULL, 8'h00);
    send_beat(ACT_RESTART, 8'h00);
    send_beat(ACT_PULL, 8'h00);
    wait_answers_drained();
  endtask

  // The receiver holds off while the sender keeps offering beats.
  task test_output_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 400;
    play_stream(150);
    wait_answers_drained();
  endtask

  // Random streams in chunks with the idling of each side switched at random.
  task test_random_streams();
    send_beat(ACT_RESTART, 8'h00);
    for (int chunk = 0; chunk < 9; chunk++) begin
      tx_idle_en = $urandom_range(0, 1);
      rx_idle_en = $urandom_range(0, 1);
      play_stream(33);
      if ($urandom_range(0, 2) == 0) wait_answers_drained();
    end
    wait_answers_drained();
  endtask

  initial begin
    restart_decoder();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_command_kinds();
    test_long_form_and_errors();
    test_output_stall();
    test_random_streams();
    wait_answers_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d answers to %0d beats; %0d decoded bytes.",
             answers_checked, beats_sent, status_tally[ST_BYTE]);
    $display("Answers: %0d accepted, %0d need input, %0d ended, %0d bad opcode,",
             status_tally[ST_ACCEPT], status_tally[ST_NEED], status_tally[ST_ENDED],
             status_tally[ST_BADOP]);
    $display("         %0d bad ref, %0d rejected.",
             status_tally[ST_BADREF], status_tally[ST_REJECT]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
